// ===== design/otq_pkg.sv =====
// Shared types and command codes for the ordered timeout queue.
package otq_pkg;

    typedef enum logic [1:0] {
        CMD_ADD    = 2'd0,
        CMD_DELETE = 2'd1,
        CMD_TICK   = 2'd2,
        CMD_EXPIRE = 2'd3
    } cmd_t;

    localparam int MAX_FIRED = 16;
    localparam int SLOT_W    = 4;
    localparam int DELAY_W   = 31;

endpackage

// ===== design/otq_cell.sv =====
// One timeout slot: deadline, pending and triggered marks, and a registered stage of the ordering chain.
module otq_cell
    import otq_pkg::*;
#(
    parameter int TIME_BITS = 32,
    parameter int IDX_W     = 4,
    parameter logic [IDX_W-1:0] INDEX = '0
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 arm,
    input  logic                 disarm,
    input  logic                 fire,
    input  logic [TIME_BITS-1:0] arm_deadline,
    input  logic [TIME_BITS-1:0] now,
    input  logic                 in_go,
    input  logic                 in_found,
    input  logic [TIME_BITS-1:0] in_key,
    input  logic [IDX_W-1:0]     in_idx,
    input  logic [1:0]           in_due_cnt,
    output logic                 out_go,
    output logic                 out_found,
    output logic [TIME_BITS-1:0] out_key,
    output logic [IDX_W-1:0]     out_idx,
    output logic [1:0]           out_due_cnt,
    output logic                 pending
);

    logic [TIME_BITS-1:0] deadline_reg;
    logic                 pending_reg;
    logic                 triggered_reg;
    logic                 go_reg;
    logic                 found_reg;
    logic [TIME_BITS-1:0] key_reg;
    logic [IDX_W-1:0]     idx_reg;
    logic [1:0]           due_cnt_reg;
    logic [1:0]           due_cnt_next;
    logic [TIME_BITS-1:0] rem;
    logic [TIME_BITS-1:0] key;
    logic                 due;
    logic                 take;

    assign rem  = deadline_reg - now;
    assign due  = pending_reg && (rem == '0 || rem[TIME_BITS-1]);
    assign key  = rem ^ {1'b1, {(TIME_BITS-1){1'b0}}};
    // earlier cells hold lower slots, so a tie keeps the earlier one
    assign take = due && (!in_found || key < in_key);
    // count due slots, saturate at two
    assign due_cnt_next = (due && in_due_cnt != 2'd2) ? in_due_cnt + 2'd1 : in_due_cnt;

    assign out_go      = go_reg;
    assign out_found   = found_reg;
    assign out_key     = key_reg;
    assign out_idx     = idx_reg;
    assign out_due_cnt = due_cnt_reg;
    assign pending     = pending_reg;

    always_ff @(posedge clk)
    begin
        if (arm)
        begin
            deadline_reg <= arm_deadline;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            go_reg      <= 1'b0;
            found_reg   <= 1'b0;
            key_reg     <= '0;
            idx_reg     <= '0;
            due_cnt_reg <= '0;
        end
        else
        begin
            go_reg      <= in_go;
            found_reg   <= in_found || due;
            key_reg     <= take ? key : in_key;
            idx_reg     <= take ? INDEX : in_idx;
            due_cnt_reg <= due_cnt_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg   <= 1'b0;
            triggered_reg <= 1'b0;
        end
        else if (arm)
        begin
            pending_reg   <= 1'b1;
            triggered_reg <= 1'b0;
        end
        else if (disarm)
        begin
            pending_reg   <= 1'b0;
            triggered_reg <= 1'b0;
        end
        else if (fire)
        begin
            pending_reg   <= 1'b0;
            triggered_reg <= 1'b1;
        end
    end

endmodule

// ===== design/ordered_timeout_queue.sv =====
// Top level of the ordered timeout queue: command decode, tick counter and row of slot cells.
// Add and tick update state when accepted; a delete gives its result in the next cycle. An expire
// sends a search wave down the row of NUM_SLOTS cells, one cell a cycle, through the launch
// register, each cell's stage and the output register, and each fired slot sends a new wave;
// up to sixteen slots come out, earliest remaining time first. An expire holds busy throughout
// and busy drops as the final word shows. Each result shows for one cycle on valid and cannot
// be held off.
module ordered_timeout_queue
    import otq_pkg::*;
#(
    parameter int NUM_SLOTS = 16,
    parameter int TIME_BITS = 32
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [1:0]           cmd,
    input  logic [SLOT_W-1:0]    slot,
    input  logic [DELAY_W-1:0]   delay,
    output logic                 valid,
    output logic [SLOT_W-1:0]    fired_slot,
    output logic                 fired_valid,
    output logic                 was_pending,
    output logic                 last
);

    localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CNT_W = $clog2(MAX_FIRED + 1);

    typedef enum logic [0:0] { ST_IDLE, ST_EXPIRE } state_t;

    state_t               state_reg;
    logic [TIME_BITS-1:0] tick_reg;
    logic [CNT_W-1:0]     count_reg;
    logic                 launch_reg;
    logic                 valid_reg;
    logic [SLOT_W-1:0]    fired_slot_reg;
    logic                 fired_valid_reg;
    logic                 was_pending_reg;
    logic                 last_reg;

    logic                 accept;
    logic                 slot_ok;
    logic [TIME_BITS-1:0] arm_deadline;
    logic [TIME_BITS-1:0] delay_ext;
    logic [NUM_SLOTS-1:0] pend;
    logic [NUM_SLOTS:0]   go_c;
    logic [NUM_SLOTS:0]   found_c;
    logic [TIME_BITS-1:0] key_c [NUM_SLOTS+1];
    logic [IDX_W-1:0]     idx_c [NUM_SLOTS+1];
    logic [1:0]           cnt_c [NUM_SLOTS+1];
    logic                 firing;

    assign accept  = start && !busy;
    assign slot_ok = ({{(32-SLOT_W){1'b0}}, slot} < 32'(NUM_SLOTS));
    assign busy    = (state_reg == ST_EXPIRE);
    generate
        if (TIME_BITS > DELAY_W)
        begin : g_wide
            assign delay_ext = {{(TIME_BITS-DELAY_W){1'b0}}, delay};
        end
        else
        begin : g_narrow
            assign delay_ext = delay[TIME_BITS-1:0];
        end
    endgenerate
    assign arm_deadline = tick_reg + delay_ext;

    assign go_c[0]    = launch_reg;
    assign found_c[0] = 1'b0;
    assign key_c[0]   = '0;
    assign idx_c[0]   = '0;
    assign cnt_c[0]   = '0;
    assign firing     = (state_reg == ST_EXPIRE) && go_c[NUM_SLOTS] && found_c[NUM_SLOTS];

    genvar g;
    generate
        for (g = 0; g < NUM_SLOTS; g++)
        begin : g_cell
            otq_cell #(
                .TIME_BITS (TIME_BITS),
                .IDX_W     (IDX_W),
                .INDEX     (IDX_W'(g))
            ) u_cell (
                .clk          (clk),
                .rst_n        (rst_n),
                .arm          (accept && cmd == CMD_ADD && slot_ok
                               && 32'(slot) == 32'(g)),
                .disarm       (accept && cmd == CMD_DELETE && slot_ok
                               && 32'(slot) == 32'(g)),
                .fire         (firing && idx_c[NUM_SLOTS] == IDX_W'(g)),
                .arm_deadline (arm_deadline),
                .now          (tick_reg),
                .in_go        (go_c[g]),
                .in_found     (found_c[g]),
                .in_key       (key_c[g]),
                .in_idx       (idx_c[g]),
                .in_due_cnt   (cnt_c[g]),
                .out_go       (go_c[g+1]),
                .out_found    (found_c[g+1]),
                .out_key      (key_c[g+1]),
                .out_idx      (idx_c[g+1]),
                .out_due_cnt  (cnt_c[g+1]),
                .pending      (pend[g])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            tick_reg        <= '0;
            count_reg       <= '0;
            launch_reg      <= 1'b0;
            valid_reg       <= 1'b0;
            fired_slot_reg  <= '0;
            fired_valid_reg <= 1'b0;
            was_pending_reg <= 1'b0;
            last_reg        <= 1'b0;
        end
        else
        begin
            launch_reg      <= 1'b0;
            valid_reg       <= 1'b0;
            fired_slot_reg  <= '0;
            fired_valid_reg <= 1'b0;
            was_pending_reg <= 1'b0;
            last_reg        <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        case (cmd)
                            CMD_TICK:
                            begin
                                tick_reg <= tick_reg + 1'b1;
                            end
                            CMD_DELETE:
                            begin
                                valid_reg       <= 1'b1;
                                last_reg        <= 1'b1;
                                was_pending_reg <= slot_ok && pend[IDX_W'(slot)];
                            end
                            CMD_EXPIRE:
                            begin
                                state_reg  <= ST_EXPIRE;
                                count_reg  <= '0;
                                launch_reg <= 1'b1;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                ST_EXPIRE:
                begin
                    if (go_c[NUM_SLOTS])
                    begin
                        valid_reg <= 1'b1;
                        if (found_c[NUM_SLOTS])
                        begin
                            fired_slot_reg  <= SLOT_W'(idx_c[NUM_SLOTS]);
                            fired_valid_reg <= 1'b1;
                            count_reg       <= count_reg + 1'b1;
                            // stop when no other slot is due or the budget is spent
                            if (count_reg == CNT_W'(MAX_FIRED - 1)
                                || cnt_c[NUM_SLOTS] != 2'd2)
                            begin
                                last_reg  <= 1'b1;
                                state_reg <= ST_IDLE;
                            end
                            else
                            begin
                                launch_reg <= 1'b1;
                            end
                        end
                        else
                        begin
                            last_reg  <= 1'b1;
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign valid       = valid_reg;
    assign fired_slot  = fired_slot_reg;
    assign fired_valid = fired_valid_reg;
    assign was_pending = was_pending_reg;
    assign last        = last_reg;

endmodule

// ===== design/otq_checker.sv =====
// Port-level checks for the ordered timeout queue, bound to the top level.
module otq_checker
    import otq_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic [1:0] cmd,
    input logic       valid,
    input logic       fired_valid,
    input logic       was_pending,
    input logic       last
);

    a_delete_one: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && cmd == CMD_DELETE) |=> (valid && last && !fired_valid))
        else $error("delete result missing");

    a_expire_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && cmd == CMD_EXPIRE) |=> busy)
        else $error("expire did not go busy");

    a_fired_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
        (valid && fired_valid) |-> !was_pending)
        else $error("fired result with was_pending");

    a_busy_end: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> (valid && last))
        else $error("expire ended without last");

endmodule

bind ordered_timeout_queue otq_checker u_otq_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .cmd         (cmd),
    .valid       (valid),
    .fired_valid (fired_valid),
    .was_pending (was_pending),
    .last        (last)
);

// ===== sim/tb_ordered_timeout_queue.sv =====
// Testbench for the ordered timeout queue: directed and random commands checked against a predictor.
`timescale 1ns / 1ps

module tb_ordered_timeout_queue;
    import otq_pkg::*;

    localparam int NSLOTS = 16;

    typedef struct packed {
        logic [SLOT_W-1:0] fired_slot;
        logic              fired_valid;
        logic              was_pending;
        logic              last;
    } fired_word_t;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [1:0]         cmd;
    logic [SLOT_W-1:0]  slot;
    logic [DELAY_W-1:0] delay;
    logic               valid;
    logic [SLOT_W-1:0]  fired_slot;
    logic               fired_valid;
    logic               was_pending;
    logic               last;

    logic [31:0]        tick_now;
    logic [31:0]        due_at [NSLOTS];
    logic               armed [NSLOTS];
    fired_word_t        pending_words [$];
    int                 errors;
    int                 words_checked;
    int                 cmds_sent;
    bit                 idle_ok;

    ordered_timeout_queue DUT (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .cmd(cmd),
        .slot(slot), .delay(delay), .valid(valid), .fired_slot(fired_slot),
        .fired_valid(fired_valid), .was_pending(was_pending), .last(last)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    task automatic predict_cmd(input cmd_t c, input logic [3:0] s, input logic [30:0] d);
        fired_word_t w;
        int          n;
        int          best;
        logic [31:0] rem;
        logic [31:0] best_key;
        n = 0;
        case (c)
            CMD_ADD:
            begin
                due_at[s] = tick_now + {1'b0, d};
                armed[s] = 1'b1;
            end
            CMD_DELETE:
            begin
                w = '{fired_slot: '0, fired_valid: 1'b0, was_pending: armed[s], last: 1'b1};
                armed[s] = 1'b0;
                pending_words.push_back(w);
            end
            CMD_TICK: tick_now = tick_now + 32'd1;
            CMD_EXPIRE:
            begin
                while (n < MAX_FIRED)
                begin
                    best = -1;
                    best_key = '0;
                    for (int i = 0; i < NSLOTS; i++)
                    begin
                        rem = due_at[i] - tick_now;
                        if (armed[i] && (rem == 0 || rem[31]))
                        begin
                            if (best < 0 || (rem ^ 32'h8000_0000) < best_key)
                            begin
                                best = i;
                                best_key = rem ^ 32'h8000_0000;
                            end
                        end
                    end
                    if (best < 0)
                        break;
                    armed[best] = 1'b0;
                    w = '{fired_slot: best[3:0], fired_valid: 1'b1, was_pending: 1'b0, last: 1'b0};
                    pending_words.push_back(w);
                    n++;
                end
                if (n == 0)
                    pending_words.push_back('{fired_slot: '0, fired_valid: 1'b0,
                                              was_pending: 1'b0, last: 1'b1});
                else
                    pending_words[$].last = 1'b1;
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic send_cmd(input cmd_t c, input logic [3:0] s, input logic [30:0] d);
        while (idle_ok && $urandom_range(99) < 29)
        begin
            start <= 1'b0;
            cmd   <= 2'($urandom_range(3));
            slot  <= 4'($urandom);
            delay <= 31'($urandom);
            @(posedge clk);
        end
        start <= 1'b1;
        cmd   <= c;
        slot  <= s;
        delay <= d;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predict_cmd(c, s, d);
        cmds_sent++;
    endtask

    task automatic drain_words();
        start <= 1'b0;
        while (pending_words.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        fired_word_t exp_w;
        if (rst_n && valid)
        begin
            if (pending_words.size() == 0)
            begin
                $display("%0t: unexpected word slot=%0d fv=%0b wp=%0b last=%0b", $time,
                         fired_slot, fired_valid, was_pending, last);
                errors++;
            end
            else
            begin
                exp_w = pending_words.pop_front();
                if (exp_w != {fired_slot, fired_valid, was_pending, last})
                begin
                    $display("%0t: expected slot=%0d fv=%0b wp=%0b last=%0b, actual slot=%0d fv=%0b wp=%0b last=%0b",
                             $time, exp_w.fired_slot, exp_w.fired_valid, exp_w.was_pending,
                             exp_w.last, fired_slot, fired_valid, was_pending, last);
                    errors++;
                end
                words_checked++;
            end
        end
    end

    task automatic test_directed();
        send_cmd(CMD_EXPIRE, 4'd0, '0);
        send_cmd(CMD_DELETE, 4'd15, '0);
        send_cmd(CMD_ADD, 4'd0, '0);
        send_cmd(CMD_ADD, 4'd15, 31'h7FFF_FFFF);
        send_cmd(CMD_ADD, 4'd7, 31'd2);
        send_cmd(CMD_ADD, 4'd3, 31'd2);
        send_cmd(CMD_ADD, 4'd9, 31'd1);
        send_cmd(CMD_DELETE, 4'd15, '0);
        send_cmd(CMD_DELETE, 4'd15, '0);
        send_cmd(CMD_EXPIRE, 4'd0, '0);
        send_cmd(CMD_TICK, 4'd0, '0);
        send_cmd(CMD_TICK, 4'd0, '0);
        send_cmd(CMD_TICK, 4'd0, '0);
        send_cmd(CMD_EXPIRE, 4'd0, '0);
        send_cmd(CMD_EXPIRE, 4'd0, '0);
        for (int i = 0; i < NSLOTS; i++)
            send_cmd(CMD_ADD, i[3:0], 31'd0);
        send_cmd(CMD_EXPIRE, 4'd0, '0);
        drain_words();
    endtask

    task automatic test_random();
        int   r;
        cmd_t c;
        for (int k = 0; k < 300; k++)
        begin
            idle_ok = !(k >= 100 && k < 160);
            r = $urandom_range(99);
            c = (r < 40) ? CMD_ADD : (r < 55) ? CMD_DELETE : (r < 80) ? CMD_TICK : CMD_EXPIRE;
            if (c == CMD_ADD && $urandom_range(3) != 0)
                send_cmd(c, 4'($urandom), 31'($urandom_range(6)));
            else
                send_cmd(c, 4'($urandom), 31'($urandom));
            if (k == 150)
                drain_words();
        end
        idle_ok = 1'b1;
        send_cmd(CMD_EXPIRE, 4'd0, '0);
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        cmd = CMD_ADD;
        slot = '0;
        delay = '0;
        tick_now = '0;
        errors = 0;
        words_checked = 0;
        cmds_sent = 0;
        idle_ok = 1'b1;
        for (int i = 0; i < NSLOTS; i++)
        begin
            armed[i] = 1'b0;
            due_at[i] = '0;
        end
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random();
        drain_words();
        repeat (40) @(posedge clk);
        $display("Sent %0d commands (add, delete, tick, expire with ties and wrap); checked %0d words.",
                 cmds_sent, words_checked);
        if (errors == 0 && pending_words.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        #10000000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
